// ===== rtl/core/ptnp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptnp_pkg
// Control word format and microprogram of the prime test / next prime core.
// ----------------------------------------------------------------------------
package ptnp_pkg;

  typedef logic [3:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT_D,
    OP_DIV_D,
    OP_DIV_D2,
    OP_STEP_D,
    OP_MARK_COMP,
    OP_MARK_PRIME,
    OP_VERDICT,
    OP_INC,
    OP_SET_OVF,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_LE3,
    C_EVEN,
    C_MOD3,
    C_DIV_BUSY,
    C_REM0,
    C_REM_NZ,
    C_SQ_GT,
    C_FOUND,
    C_NOT_TOP,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  localparam pc_t STEP_IDLE  = 4'd0;
  localparam pc_t STEP_SMALL = 4'd1;
  localparam pc_t STEP_EVEN  = 4'd2;
  localparam pc_t STEP_MOD3  = 4'd3;
  localparam pc_t STEP_INIT  = 4'd4;
  localparam pc_t STEP_LOOP  = 4'd5;
  localparam pc_t STEP_WD    = 4'd6;
  localparam pc_t STEP_CD    = 4'd7;
  localparam pc_t STEP_WD2   = 4'd8;
  localparam pc_t STEP_CD2   = 4'd9;
  localparam pc_t STEP_COMP  = 4'd10;
  localparam pc_t STEP_PRIME = 4'd11;
  localparam pc_t STEP_NEXT  = 4'd12;
  localparam pc_t STEP_INC   = 4'd13;
  localparam pc_t STEP_OVF   = 4'd14;
  localparam pc_t STEP_DONE  = 4'd15;

  // Jump to target when cond holds, else fall through to the next step.
  // The last step falls through to step 0 (idle).
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    unique case (pc)
      STEP_IDLE:  w = '{OP_NOP,        C_ALWAYS,   STEP_IDLE};
      STEP_SMALL: w = '{OP_NOP,        C_LE3,      STEP_PRIME};
      STEP_EVEN:  w = '{OP_NOP,        C_EVEN,     STEP_COMP};
      STEP_MOD3:  w = '{OP_NOP,        C_MOD3,     STEP_COMP};
      STEP_INIT:  w = '{OP_INIT_D,     C_NEVER,    STEP_IDLE};
      STEP_LOOP:  w = '{OP_DIV_D,      C_SQ_GT,    STEP_PRIME};
      STEP_WD:    w = '{OP_NOP,        C_DIV_BUSY, STEP_WD};
      STEP_CD:    w = '{OP_DIV_D2,     C_REM0,     STEP_COMP};
      STEP_WD2:   w = '{OP_NOP,        C_DIV_BUSY, STEP_WD2};
      STEP_CD2:   w = '{OP_STEP_D,     C_REM_NZ,   STEP_LOOP};
      STEP_COMP:  w = '{OP_MARK_COMP,  C_ALWAYS,   STEP_NEXT};
      STEP_PRIME: w = '{OP_MARK_PRIME, C_NEVER,    STEP_IDLE};
      STEP_NEXT:  w = '{OP_VERDICT,    C_FOUND,    STEP_DONE};
      STEP_INC:   w = '{OP_INC,        C_NOT_TOP,  STEP_SMALL};
      STEP_OVF:   w = '{OP_SET_OVF,    C_NEVER,    STEP_IDLE};
      STEP_DONE:  w = '{OP_EMIT,       C_OUT_BUSY, STEP_DONE};
      default:    w = '{OP_NOP,        C_ALWAYS,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/prime_test_and_next_prime_core.sv =====
// ----------------------------------------------------------------------------
// prime_test_and_next_prime_core
// Trial-division prime test of the input and search for the next prime above.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_ready_o with number_in_i (two's complement).
// Output channel: out_valid_o / out_ready_i with input_is_prime_o,
// next_larger_prime_o and search_overflow_o; one result per input transfer.
// Control is a 16-step microprogram (ptnp_pkg::ucode) over one shared
// restoring remainder unit that retires one bit per cycle; the sequencer
// waits in a polling step until each trial modulo is done. The
// checks for 2 and 3 take three steps (mod 3 is a digit-sum compare), and
// each divisor pair 6k-1/6k+1 is tried with two modulos in turn; the
// search repeats the test for each candidate until a prime is found or
// the top of the range is reached. Inputs at most 1 (or negative) go
// straight to the final step. Latency is data dependent; one item is
// processed at a time.
// in_ready_o is high only while the sequencer is idle. The result goes to
// an output register, so the next item is accepted while a result waits;
// a stalled receiver holds the block at its final step only when a second
// result is ready. Reset returns the sequencer to idle and drops
// out_valid_o; no results are held across reset.
// ----------------------------------------------------------------------------
module prime_test_and_next_prime_core
  import ptnp_pkg::*;
#(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [NUMBER_WIDTH-1:0]   number_in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      input_is_prime_o,
  output logic [NUMBER_WIDTH-2:0]   next_larger_prime_o,
  output logic                      search_overflow_o
);

  localparam int CW   = NUMBER_WIDTH - 1;
  localparam int SQW  = 2 * NUMBER_WIDTH;
  localparam int CNTW = $clog2(NUMBER_WIDTH);
  localparam int ND   = (CW + 1) / 2;
  localparam int DSW  = $clog2(3 * ND + 1);

  // 4 = 1 mod 3, so the sum of base-4 digits keeps the residue
  function automatic logic mult_of_three(input logic [CW-1:0] v);
    logic [2*ND-1:0] pad;
    logic [DSW-1:0]  sum;
    logic            hit;
    pad = (2*ND)'(v);
    sum = '0;
    hit = 1'b0;
    for (int i = 0; i < ND; i++) begin
      sum = sum + DSW'(pad[2*i +: 2]);
    end
    for (int k = 0; k <= 3 * ND; k += 3) begin
      if (sum == DSW'(k)) hit = 1'b1;
    end
    return hit;
  endfunction

  pc_t   pc_q, pc_d;
  ctrl_t ctrl;
  logic  cond_ok;
  logic  in_xfer, out_free, trivial;

  logic [CW-1:0]   cand_q, d_q, divisor_q, shift_q, rem_q;
  logic [SQW-1:0]  sq_q;
  logic [CNTW-1:0] cnt_q;
  logic            first_q, verdict_q, is_prime_q, ovf_q;
  logic            out_valid_q;
  logic            out_prime_q, out_ovf_q;
  logic [CW-1:0]   out_next_q;

  logic            div_busy, div_start;
  logic [CW:0]     div_t, div_sub;
  logic            div_ge;

  assign ctrl       = ucode(pc_q);
  assign in_ready_o = (pc_q == STEP_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign trivial    = number_in_i[NUMBER_WIDTH-1] | (number_in_i[CW-1:0] <= CW'(1));

  assign div_busy  = (cnt_q != '0);
  assign div_start = (ctrl.op == OP_DIV_D) | (ctrl.op == OP_DIV_D2);
  assign div_t     = {rem_q, shift_q[CW-1]};
  assign div_ge    = (div_t >= {1'b0, divisor_q});
  assign div_sub   = div_t - {1'b0, divisor_q};

  always_comb begin
    case (ctrl.cond)
      C_NEVER:    cond_ok = 1'b0;
      C_ALWAYS:   cond_ok = 1'b1;
      C_LE3:      cond_ok = (cand_q <= CW'(3));
      C_EVEN:     cond_ok = ~cand_q[0];
      C_MOD3:     cond_ok = mult_of_three(cand_q);
      C_DIV_BUSY: cond_ok = div_busy;
      C_REM0:     cond_ok = (rem_q == '0);
      C_REM_NZ:   cond_ok = (rem_q != '0);
      C_SQ_GT:    cond_ok = (sq_q > SQW'(cand_q));
      C_FOUND:    cond_ok = ~first_q & verdict_q;
      C_NOT_TOP:  cond_ok = (cand_q != '1);
      C_OUT_BUSY: cond_ok = ~out_free;
      default:    cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    if (in_xfer) begin
      pc_d = trivial ? STEP_DONE : STEP_SMALL;
    end else if (cond_ok) begin
      pc_d = ctrl.target;
    end else begin
      pc_d = pc_q + 4'd1;
    end
  end

  // sequencer, remainder counter and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (div_start) begin
        cnt_q <= CNTW'(CW);
      end else if (div_busy) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
      if (ctrl.op == OP_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      first_q    <= 1'b1;
      ovf_q      <= 1'b0;
      is_prime_q <= 1'b0;
      cand_q     <= trivial ? CW'(2) : number_in_i[CW-1:0];
    end
    if (div_start) begin
      rem_q     <= '0;
      shift_q   <= cand_q;
      divisor_q <= (ctrl.op == OP_DIV_D) ? d_q : d_q + CW'(2);
    end else if (div_busy) begin
      rem_q   <= div_ge ? div_sub[CW-1:0] : div_t[CW-1:0];
      shift_q <= {shift_q[CW-2:0], 1'b0};
    end
    case (ctrl.op)
      OP_INIT_D: begin
        d_q  <= CW'(5);
        sq_q <= SQW'(25);
      end
      OP_STEP_D: begin
        d_q  <= d_q + CW'(6);
        sq_q <= sq_q + (SQW'(d_q) << 3) + (SQW'(d_q) << 2) + SQW'(36);
      end
      OP_MARK_COMP:  verdict_q <= 1'b0;
      OP_MARK_PRIME: verdict_q <= 1'b1;
      OP_VERDICT: begin
        if (first_q) begin
          is_prime_q <= verdict_q;
        end
      end
      OP_INC: begin
        cand_q  <= cand_q + CW'(1);
        first_q <= 1'b0;
      end
      OP_SET_OVF: ovf_q <= 1'b1;
      OP_EMIT: begin
        if (out_free) begin
          out_prime_q <= is_prime_q;
          out_ovf_q   <= ovf_q;
          out_next_q  <= ovf_q ? '0 : cand_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o         = out_valid_q;
  assign input_is_prime_o    = out_prime_q;
  assign next_larger_prime_o = out_next_q;
  assign search_overflow_o   = out_ovf_q;

endmodule

// ===== verif/tb_prime_test_and_next_prime_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_prime_test_and_next_prime_core
// Self-checking bench for the prime test / next prime core.
// Numbers go in over a valid/ready channel. For each transfer a trial-division
// model predicts the primality flag, the next prime above and the overflow
// flag. Each result transfer is compared in order. Covered: sign and small
// values, divisor pair boundaries, top of range, long output stall,
// pause-until-drained and a mixed random run.
// ----------------------------------------------------------------------------
module tb_prime_test_and_next_prime_core;

  localparam int NW = 32;
  localparam longint unsigned TOP_POS = (64'd1 << (NW - 1)) - 64'd1;

  typedef struct {
    logic [NW-1:0] num;
    logic          prime_bit;
    logic [NW-2:0] next_up;
    logic          overflow;
  } prime_answer_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  logic [NW-1:0] number_in_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic          input_is_prime_o;
  logic [NW-2:0] next_larger_prime_o;
  logic          search_overflow_o;

  prime_answer_t answer_q[$];
  int            err_count    = 0;
  bit            no_idle      = 1'b0;
  int unsigned   hold_request = 0;
  logic          sink_block   = 1'b0;
  int unsigned   sink_wait    = 0;

  prime_test_and_next_prime_core #(
    .NUMBER_WIDTH(NW)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .number_in_i        (number_in_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .input_is_prime_o   (input_is_prime_o),
    .next_larger_prime_o(next_larger_prime_o),
    .search_overflow_o  (search_overflow_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit trial_prime(longint unsigned n);
    longint unsigned d;
    if (n <= 1) return 1'b0;
    if (n <= 3) return 1'b1;
    if ((n % 2) == 0 || (n % 3) == 0) return 1'b0;
    for (d = 5; d <= n / d; d += 6) begin
      if ((n % d) == 0 || (n % (d + 2)) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic prime_answer_t predict_answer(logic [NW-1:0] num);
    prime_answer_t   a;
    longint unsigned raw;
    longint unsigned cand;
    raw         = 64'(num);
    a.num       = num;
    a.prime_bit = 1'b0;
    a.next_up   = '0;
    a.overflow  = 1'b0;
    if (num[NW-1] || raw <= 1) begin
      a.next_up = (NW-1)'(2);
    end else begin
      a.prime_bit = trial_prime(raw);
      a.overflow  = 1'b1;
      cand = raw;
      while (cand < TOP_POS) begin
        cand++;
        if (trial_prime(cand)) begin
          a.next_up  = cand[NW-2:0];
          a.overflow = 1'b0;
          break;
        end
      end
    end
    return a;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ERROR: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_answer();
    prime_answer_t want;
    if (answer_q.size() == 0) begin
      report_mismatch($sformatf("result with no pending request (next %0d)",
                                next_larger_prime_o));
    end else begin
      want = answer_q.pop_front();
      if (input_is_prime_o !== want.prime_bit)
        report_mismatch($sformatf("number %0d: input_is_prime got %0b want %0b",
                                  $signed(want.num), input_is_prime_o, want.prime_bit));
      if (next_larger_prime_o !== want.next_up)
        report_mismatch($sformatf("number %0d: next_larger_prime got %0d want %0d",
                                  $signed(want.num), next_larger_prime_o,
                                  want.next_up));
      if (search_overflow_o !== want.overflow)
        report_mismatch($sformatf("number %0d: search_overflow got %0b want %0b",
                                  $signed(want.num), search_overflow_o, want.overflow));
    end
  endtask

  // result side: per-transfer random wait, forced low during a long hold
  always @(posedge clk_i or negedge rst_ni) begin : sink_side
    int unsigned w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_wait   <= 0;
    end else if (out_valid_o && out_ready_i) begin
      check_answer();
      w = no_idle ? 0 : $urandom_range(0, 15);
      sink_wait <= w;
      out_ready_i <= !sink_block && (w == 0);
    end else if (sink_block) begin
      out_ready_i <= 1'b0;
    end else if (!out_ready_i) begin
      if (sink_wait == 0) out_ready_i <= 1'b1;
      else sink_wait <= sink_wait - 1;
    end
  end

  // long receiver hold, length in cycles set by a test
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        sink_block <= 1'b1;
        repeat (hold_request) @(posedge clk_i);
        hold_request = 0;
        sink_block <= 1'b0;
      end
    end
  end

  // one number transfer; valid drops after each one before the next is offered
  task automatic send_number(logic [NW-1:0] num);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    repeat (gap + 1) @(posedge clk_i);
    in_valid_i  <= 1'b1;
    number_in_i <= num;
    do @(posedge clk_i); while (!in_ready_o);
    answer_q.push_back(predict_answer(num));
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (answer_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_sign_and_small();
    send_number(32'h8000_0000);
    send_number(32'hFFFF_FFFF);
    send_number(-32'sd7);
    send_number(32'hAAAA_AAAA);
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'd2);
    send_number(32'd3);
    send_number(32'd4);
  endtask

  task automatic test_divisor_pairs();
    send_number(32'd5);
    send_number(32'd7);
    send_number(32'd9);
    send_number(32'd25);
    send_number(32'd35);
    send_number(32'd49);
    send_number(32'd121);
    send_number(32'd143);
    send_number(32'd89);
    send_number(32'd113);
    send_number(32'd1000);
  endtask

  task automatic test_top_of_range();
    send_number(32'h7FFF_FFFF);
    send_number(32'h7FFF_FFFE);
  endtask

  task automatic test_output_stall();
    int i;
    wait_drained();
    no_idle      = 1'b1;
    hold_request = 400;
    for (i = 0; i < 10; i++) begin
      if (i % 2 == 0) send_number($urandom | 32'h8000_0000);
      else send_number($urandom_range(0, 40));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_pause_for_drain();
    int i;
    for (i = 0; i < 3; i++) send_number($urandom_range(2, 500));
    wait_drained();
    for (i = 0; i < 3; i++) send_number($urandom_range(2, 500));
  endtask

  task automatic test_random();
    int            i;
    int unsigned   pick;
    logic [NW-1:0] num;
    for (i = 0; i < 60; i++) begin
      if (i % 16 == 0) no_idle = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 31);
      if (pick <= 5) num = $urandom | 32'h8000_0000;
      else if (pick <= 7) num = $urandom_range(0, 3);
      else if (pick <= 17) num = $urandom_range(2, 255);
      else if (pick <= 28) num = $urandom_range(256, 65535);
      else if (pick <= 30) num = $urandom_range(65536, 1 << 20);
      else num = $urandom_range(1 << 24, 1 << 25);
      send_number(num);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_sign_and_small();
    test_divisor_pairs();
    test_top_of_range();
    test_output_stall();
    test_pause_for_drain();
    test_random();
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
